// ===== rtl/tdli_pkg.sv =====
package tdli_pkg;

    localparam int unsigned DepthDefault = 1024;
    localparam logic [31:0] MaxDelayReset = 32'd65536;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_ORDER     = 3'd2,
        ST_BAD_DELAY = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        sample_time;
        logic signed [31:0] sample_value;
        logic [31:0]        delay;
    } item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
    } result_t;

    // muldiv request/response between the top level and the divide unit
    typedef struct packed {
        logic        start;
        logic [32:0] mag_v;
        logic [32:0] mag_t;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [40:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/tdli_muldiv.sv =====
module tdli_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  tdli_pkg::div_req_t req,
    output tdli_pkg::div_rsp_t rsp
);
    import tdli_pkg::*;

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } md_state_t;

    md_state_t   state_reg, state_next;
    logic [32:0] a_reg, b_reg, d_reg;
    logic [65:0] prod_reg;
    logic [1:0]  mstep_reg;
    logic [6:0]  bit_reg;
    logic [33:0] rem_reg;
    logic [40:0] q_reg;

    logic [16:0] a_half;
    logic [32:0] b_part;
    logic [49:0] pp;
    logic [33:0] rem_sh;
    logic        ge;
    logic [41:0] q_sh;

    always_comb
    begin
        a_half = mstep_reg[0] ? {1'b0, a_reg[32:17]} : a_reg[16:0];
        b_part = b_reg;
        pp     = 50'(a_half) * 50'(b_part);
        rem_sh = {rem_reg[32:0], prod_reg[bit_reg]};
        ge     = rem_sh >= {1'b0, d_reg};
        q_sh   = {q_reg, ge};
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL:  if (mstep_reg == 2'd1) state_next = MD_DIV;
            MD_DIV:  if (bit_reg == 7'd0) state_next = MD_DONE;
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MD_IDLE:
            begin
                a_reg     <= req.mag_v;
                b_reg     <= req.mag_t;
                d_reg     <= req.den;
                prod_reg  <= '0;
                mstep_reg <= '0;
            end
            MD_MUL:
            begin
                // two 17x33 partial products
                if (mstep_reg[0])
                    prod_reg <= prod_reg + {pp[48:0], 17'd0};
                else
                    prod_reg <= 66'(pp);
                mstep_reg <= mstep_reg + 2'd1;
                bit_reg   <= 7'd65;
                rem_reg   <= '0;
                q_reg     <= '0;
            end
            MD_DIV:
            begin
                rem_reg <= ge ? rem_sh - {1'b0, d_reg} : rem_sh;
                // cap the quotient as it forms
                q_reg   <= (q_sh > 42'h100_0000_0000) ? 41'h100_0000_0000 : q_sh[40:0];
                bit_reg <= bit_reg - 7'd1;
            end
            MD_DONE: ;
            default: ;
        endcase
    end

    assign rsp.done     = (state_reg == MD_DONE);
    assign rsp.quotient = q_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> state_reg == MD_IDLE) else $error("muldiv done not followed by idle");
    a_mul_two: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == MD_MUL) |=> state_reg == MD_MUL) else $error("multiply too short");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DIV |-> bit_reg <= 7'd65) else $error("divide bit index out of range");

endmodule

// ===== rtl/timestamped_delay_line_interp_unit.sv =====
// Adds and gets run a binary search of P probes over the ring, P at most clog2(DEPTH+1);
// a get that interpolates then also waits for the divider. Rejected adds end after the
// duplicate/order check; gets with a bad delay or an empty ring go straight to the result.
// Throughput: one item at a time; busy is high from the accept until the result strobe.
// Each result is shown for one cycle on result/done; the receiver cannot stall.
// Reset clears the ring to empty and max_delay to 65536; the sample memories are not cleared.
module timestamped_delay_line_interp_unit #(
    parameter int unsigned DEPTH = tdli_pkg::DepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tdli_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output tdli_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);
    import tdli_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(DEPTH);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_NEWRD  = 13'b0000000000010,
        S_NEWCHK = 13'b0000000000100,
        S_WRITE  = 13'b0000000001000,
        S_SRCH   = 13'b0000000010000,
        S_SWAIT  = 13'b0000000100000,
        S_PRUNE  = 13'b0000001000000,
        S_GSEL   = 13'b0000010000000,
        S_RD1    = 13'b0000100000000,
        S_RD2    = 13'b0001000000000,
        S_RD2W   = 13'b0010000000000,
        S_DIVW   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   oldest_reg;
    logic [CW-1:0]   count_reg;
    logic [31:0]     max_delay_reg;
    item_t           item_reg;
    logic [CW-1:0]   lo_reg, hi_reg;
    logic [32:0]     key_reg;          // signed 33-bit search key
    logic            key_neg_reg;
    logic [31:0]     t1_reg, v1_reg;
    logic [2:0]      status_reg;
    logic [31:0]     res_reg;
    logic            exact_reg;
    logic [1:0]      rd_phase_reg;

    logic [31:0]     time_mem [DEPTH];
    logic [31:0]     value_mem [DEPTH];
    logic [31:0]     rd_time, rd_value;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;

    div_req_t        dreq;
    div_rsp_t        drsp;

    logic [CW-1:0]   mid;
    logic [CW-1:0]   rd_idx;
    logic            t_lt_key;
    logic [CW-1:0]   drop;
    logic [32:0]     dv, dt, mag_v, mag_t;
    logic            neg;
    logic [33:0]     sum;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [CW-1:0] i);
        logic [CW:0] s;
        begin
            s = (CW+1)'(base) + (CW+1)'(i);
            if (s >= (CW+1)'(DEPTH))
                s = s - (CW+1)'(DEPTH);
            slot_of = s[AW-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[wr_addr]  <= item_reg.sample_time;
            value_mem[wr_addr] <= item_reg.sample_value;
        end
        rd_time  <= time_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

    tdli_muldiv u_muldiv (
        .clk (clk),
        .rst_n (rst_n),
        .req (dreq),
        .rsp (drsp)
    );

    always_comb
    begin
        mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
        t_lt_key = key_neg_reg ? 1'b0 : ({1'b0, rd_time} < key_reg);
        drop     = (lo_reg != '0) ? lo_reg - CW'(1) : '0;
        dv       = {rd_value[31], rd_value} - {v1_reg[31], v1_reg};
        dt       = key_reg - {1'b0, t1_reg};
        neg      = dv[32] ^ dt[32];
        mag_v    = dv[32] ? -dv : dv;
        mag_t    = dt[32] ? -dt : dt;
        sum      = neg ? {{2{v1_reg[31]}}, v1_reg} - {2'b00, drsp.quotient[31:0]}
                       : {{2{v1_reg[31]}}, v1_reg} + {2'b00, drsp.quotient[31:0]};
        // a quotient of 2^32 or more saturates whatever the anchor value
        if (drsp.quotient[40:32] != '0)
            sum = neg ? {2'b11, 32'h0} : {2'b01, 32'h0};
        rd_idx   = '0;
        unique case (state_reg)
            S_NEWRD:  rd_idx = count_reg - CW'(1);
            S_GSEL, S_RD1: rd_idx = (rd_phase_reg == 2'd0) ? lo_reg - CW'(1) : lo_reg;
            default:  rd_idx = mid;
        endcase
        rd_addr  = slot_of(oldest_reg, rd_idx);
        mem_we   = (state_reg == S_WRITE);
        wr_addr  = (count_reg == DepthC) ? oldest_reg : slot_of(oldest_reg, count_reg);
        dreq.start = 1'b0;
        dreq.mag_v = mag_v;
        dreq.mag_t = mag_t;
        dreq.den   = {1'b0, rd_time} - {1'b0, t1_reg};
        // start the divider only when the item really interpolates
        if (state_reg == S_RD2W && !exact_reg && {1'b0, rd_time} != key_reg
            && lo_reg != '0 && rd_time != t1_reg)
            dreq.start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            max_delay_reg <= MaxDelayReset;
            rd_phase_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                max_delay_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg  <= item;
                        state_reg <= S_NEWRD;
                        if (item.opcode == OP_GET)
                        begin
                            res_reg <= '0;
                            if (item.delay > max_delay_reg)
                            begin
                                status_reg <= ST_BAD_DELAY;
                                state_reg  <= S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                key_reg     <= {1'b0, item.sample_time} - {1'b0, item.delay};
                                key_neg_reg <= item.delay > item.sample_time;
                                lo_reg      <= '0;
                                hi_reg      <= count_reg;
                                state_reg   <= S_SWAIT;
                            end
                        end
                    end
                end
                S_NEWRD:  state_reg <= S_NEWCHK;
                S_NEWCHK:
                begin
                    res_reg <= '0;
                    if (count_reg != '0 && item_reg.sample_time == rd_time)
                    begin
                        status_reg <= ST_DUPLICATE;
                        state_reg  <= S_OUT;
                    end
                    else if (count_reg != '0 && item_reg.sample_time < rd_time)
                    begin
                        status_reg <= ST_ORDER;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (count_reg == DepthC)
                        oldest_reg <= slot_of(oldest_reg, CW'(1));
                    else
                        count_reg <= count_reg + CW'(1);
                    key_reg     <= {1'b0, item_reg.sample_time} - {1'b0, max_delay_reg};
                    key_neg_reg <= max_delay_reg > item_reg.sample_time;
                    lo_reg      <= '0;
                    hi_reg      <= (count_reg == DepthC) ? count_reg : count_reg + CW'(1);
                    state_reg   <= S_SWAIT;
                end
                S_SWAIT:  state_reg <= S_SRCH;
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        if (t_lt_key)
                            lo_reg <= mid + CW'(1);
                        else
                            hi_reg <= mid;
                        state_reg <= S_SWAIT;
                    end
                    else
                        state_reg <= (item_reg.opcode == OP_ADD) ? S_PRUNE : S_GSEL;
                end
                S_PRUNE:
                begin
                    oldest_reg <= slot_of(oldest_reg, drop);
                    count_reg  <= count_reg - drop;
                    state_reg  <= S_OUT;
                end
                S_GSEL:
                begin
                    status_reg <= ST_OK;
                    // past newest: use the last two samples
                    if (lo_reg >= count_reg)
                    begin
                        lo_reg    <= count_reg - CW'(1);
                        exact_reg <= (count_reg == CW'(1));
                    end
                    else
                        exact_reg <= 1'b0;
                    rd_phase_reg <= 2'd0;
                    state_reg    <= S_RD1;
                end
                S_RD1:
                begin
                    rd_phase_reg <= 2'd1;
                    state_reg    <= S_RD2;
                end
                S_RD2:
                begin
                    t1_reg    <= rd_time;
                    v1_reg    <= rd_value;
                    state_reg <= S_RD2W;
                end
                S_RD2W:
                begin
                    rd_phase_reg <= 2'd0;
                    if (exact_reg || {1'b0, rd_time} == key_reg)
                    begin
                        res_reg   <= rd_value;
                        state_reg <= S_OUT;
                    end
                    else if (lo_reg == '0)
                    begin
                        status_reg <= ST_BAD_DELAY;
                        state_reg  <= S_OUT;
                    end
                    else if (rd_time == t1_reg)
                    begin
                        res_reg   <= v1_reg;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        if (sum[33] && sum[32:31] != 2'b11)
                            res_reg <= 32'h8000_0000;
                        else if (!sum[33] && sum[32:31] != 2'b00)
                            res_reg <= 32'h7FFF_FFFF;
                        else
                            res_reg <= sum[31:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:    state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);
    assign result.result_value = res_reg;
    assign result.status       = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DepthC) else $error("entry count above depth");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.result_value == '0)
        else $error("nonzero value with error status");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result shown while idle");

endmodule

// ===== sim/tb_timestamped_delay_line_interp_unit.sv =====
module tb_timestamped_delay_line_interp_unit;
    import tdli_pkg::*;

    localparam int unsigned RING = 1024;

    logic        clk;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    timestamped_delay_line_interp_unit #(.DEPTH(RING)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [31:0] ring_time [RING];
    logic [31:0] ring_val [RING];
    int unsigned head_pos;
    int unsigned fill;
    logic [31:0] window;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      error_count;
    int      gap_left;
    bit      quiet;
    bit      in_flight;
    logic [31:0] newest_time;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("tb_timestamped_delay_line_interp_unit: done, errors");
        $finish;
    end

    function automatic logic [31:0] t_of(int unsigned i);
        return ring_time[(head_pos + i) % RING];
    endfunction

    function automatic logic [31:0] v_of(int unsigned i);
        return ring_val[(head_pos + i) % RING];
    endfunction

    function automatic int unsigned first_at_or_above(longint key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = fill;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (longint'({32'd0, t_of(mid)}) < key) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic signed [31:0] line_value(logic [31:0] t1, logic [31:0] v1r,
                                                      logic [31:0] t2, logic [31:0] v2r,
                                                      longint tp);
        longint v1;
        longint dv;
        longint dt;
        logic [63:0] den;
        logic [127:0] prod;
        logic [127:0] q;
        longint r;
        bit neg;
        v1 = longint'($signed(v1r));
        dv = longint'($signed(v2r)) - v1;
        dt = tp - longint'({32'd0, t1});
        den = {32'd0, t2} - {32'd0, t1};
        if (den == 0) return v1r;
        neg = (dv < 0) != (dt < 0);
        prod = 128'(dv < 0 ? -dv : dv) * 128'(dt < 0 ? -dt : dt);
        q = prod / 128'(den);
        if (q > 128'h100_0000_0000) q = 128'h100_0000_0000;
        r = neg ? v1 - longint'(q[63:0]) : v1 + longint'(q[63:0]);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic result_t predict_delay_line(item_t it);
        result_t res;
        int unsigned found;
        int unsigned drop;
        int unsigned k;
        longint tp;
        res.result_value = '0;
        res.status = ST_OK;
        if (it.opcode == OP_ADD)
        begin
            if (fill > 0 && it.sample_time == t_of(fill - 1))
                res.status = ST_DUPLICATE;
            else if (fill > 0 && it.sample_time < t_of(fill - 1))
                res.status = ST_ORDER;
            else
            begin
                if (fill >= RING)
                begin
                    ring_time[head_pos] = it.sample_time;
                    ring_val[head_pos] = it.sample_value;
                    head_pos = (head_pos + 1) % RING;
                end
                else
                begin
                    ring_time[(head_pos + fill) % RING] = it.sample_time;
                    ring_val[(head_pos + fill) % RING] = it.sample_value;
                    fill++;
                end
                found = first_at_or_above(longint'({32'd0, it.sample_time})
                                          - longint'({32'd0, window}));
                drop = found > 0 ? found - 1 : 0;
                head_pos = (head_pos + drop) % RING;
                fill -= drop;
            end
            return res;
        end
        tp = longint'({32'd0, it.sample_time}) - longint'({32'd0, it.delay});
        if (it.delay > window) res.status = ST_BAD_DELAY;
        else if (fill == 0) res.status = ST_EMPTY;
        else
        begin
            k = first_at_or_above(tp);
            if (k >= fill)
            begin
                if (fill > 1)
                    res.result_value = line_value(t_of(fill - 2), v_of(fill - 2),
                                                  t_of(fill - 1), v_of(fill - 1), tp);
                else
                    res.result_value = v_of(0);
            end
            else if (longint'({32'd0, t_of(k)}) == tp)
                res.result_value = v_of(k);
            else if (k == 0)
                res.status = ST_BAD_DELAY;
            else
                res.result_value = line_value(t_of(k - 1), v_of(k - 1), t_of(k), v_of(k), tp);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    task automatic queue_item(item_t it);
        pending_items = {pending_items, it};
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_results = {expected_results, predict_delay_line(item)};
            void'(pending_items.pop_front());
            in_flight <= 1'b1;
        end
        if (rst_n && done)
        begin
            in_flight <= 1'b0;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result.result_value, 32'd0);
            else
            begin
                if (result.result_value !== expected_results[0].result_value)
                    report_mismatch("result_value", result.result_value,
                                    expected_results[0].result_value);
                if (result.status !== expected_results[0].status)
                    report_mismatch("status", {29'd0, result.status},
                                    {29'd0, expected_results[0].status});
                void'(expected_results.pop_front());
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (pending_items.size() > 0 && !busy && !in_flight)
        begin
            if (!quiet && !start && $urandom_range(0, 5) == 0)
            begin
                gap_left <= $urandom_range(1, 18);
                start <= 1'b0;
            end
            else
            begin
                item <= pending_items[0];
                start <= 1'b1;
            end
        end
        else
            start <= 1'b0;
    end

    function automatic item_t make_item(logic op, logic [31:0] t, logic [31:0] v,
                                        logic [31:0] d);
        item_t it;
        it.opcode = op;
        it.sample_time = t;
        it.sample_value = v;
        it.delay = d;
        return it;
    endfunction

    task automatic drain_and_set_window(logic [31:0] w);
        while (pending_items.size() > 0 || expected_results.size() > 0 || in_flight)
            @(posedge clk);
        repeat (120) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        window = w;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random_phase(int count, logic [31:0] step_max);
        logic [31:0] t;
        logic [31:0] d;
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                newest_time = newest_time + $urandom_range(1, step_max);
                queue_item(make_item(OP_ADD, newest_time, $urandom(), $urandom()));
            end
            else if (r < 50)
            begin
                t = ($urandom_range(0, 1)) ? newest_time : newest_time - $urandom_range(0, 300);
                queue_item(make_item(OP_ADD, t, $urandom(), $urandom()));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: d = $urandom();
                    1: d = window;
                    default: d = (window == 0) ? 0 : $urandom_range(0, window);
                endcase
                t = newest_time + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000) : 0);
                queue_item(make_item(OP_GET, t, $urandom(), d));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        gap_left = 0;
        quiet = 1'b0;
        in_flight = 1'b0;
        head_pos = 0;
        fill = 0;
        window = MaxDelayReset;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty, bad delay, single sample, exact, interpolation, extremes
        queue_item(make_item(OP_GET, 32'd100, 32'd0, 32'd0));
        queue_item(make_item(OP_GET, 32'd100, 32'd0, 32'd65537));
        queue_item(make_item(OP_ADD, 32'd1000, 32'h7fff_ffff, 32'd0));
        queue_item(make_item(OP_GET, 32'd5000, 32'd0, 32'd0));
        queue_item(make_item(OP_ADD, 32'd1000, 32'd5, 32'd0));
        queue_item(make_item(OP_ADD, 32'd999, 32'd5, 32'd0));
        queue_item(make_item(OP_ADD, 32'd2000, 32'h8000_0000, 32'd0));
        queue_item(make_item(OP_GET, 32'd2000, 32'd0, 32'd1000));
        queue_item(make_item(OP_GET, 32'd2000, 32'd0, 32'd333));
        queue_item(make_item(OP_GET, 32'd9000, 32'd0, 32'd0));
        queue_item(make_item(OP_GET, 32'd1500, 32'd0, 32'd1000));
        queue_item(make_item(OP_ADD, 32'd3000, 32'd0, 32'hffff_ffff));
        queue_item(make_item(OP_ADD, 32'd200000, 32'd12345, 32'd0));
        queue_item(make_item(OP_GET, 32'd200000, 32'd0, 32'd65536));
        newest_time = 32'd200000;

        // huge window: nothing is pruned and far-back points fall before the oldest
        drain_and_set_window(32'hffff_ffff);
        queue_random_phase(40, 32'd10);

        drain_and_set_window(32'd70000);
        queue_random_phase(600, 32'd300);
        drain_and_set_window(32'd1000);
        queue_random_phase(600, 32'd40);

        // window zero keeps just two points
        drain_and_set_window(32'd0);
        quiet = 1'b1;
        queue_random_phase(540, 32'd5);

        // top of the time range
        queue_item(make_item(OP_ADD, 32'hffff_ffff, 32'hffff_0000, 32'd0));
        queue_item(make_item(OP_GET, 32'hffff_ffff, 32'd0, 32'd1));
        drain_and_set_window(32'hffff_ffff);
        queue_item(make_item(OP_GET, 32'd0, 32'd0, 32'hffff_ffff));
        queue_item(make_item(OP_GET, 32'hffff_ffff, 32'd0, 32'hffff_ffff));
        drain_and_set_window(32'd0);
        queue_item(make_item(OP_ADD, 32'hffff_ffff, 32'd7, 32'd0));
        queue_item(make_item(OP_GET, 32'hffff_ffff, 32'd0, 32'd0));

        while (pending_items.size() > 0 || expected_results.size() > 0 || in_flight)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (error_count == 0)
            $display("tb_timestamped_delay_line_interp_unit: done, clean");
        else
            $display("tb_timestamped_delay_line_interp_unit: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tdli_pkg.sv
rtl/tdli_muldiv.sv
rtl/timestamped_delay_line_interp_unit.sv
sim/tb_timestamped_delay_line_interp_unit.sv
